// File: sv/scpf_pkg.sv
// Shared types and constants for the sensor command packet framer.
// No dependencies; imported by every module of the block.
package scpf_pkg;

  localparam int unsigned PARAM_FIELDS   = 5;
  localparam int unsigned MAX_PARAMS_DEF = 5;
  localparam int unsigned FIXED_BYTES    = 12;   // header..opcode plus checksum

  localparam logic [7:0]  HDR_HI     = 8'hEF;
  localparam logic [7:0]  HDR_LO     = 8'h01;
  localparam logic [7:0]  PKT_FLAG   = 8'h01;
  localparam logic [31:0] ADDR_RESET = 32'hFFFF_FFFF;

  // One packet byte as it sits in a cell of the output chain.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } scpf_beat_t;

endpackage

// File: sv/scpf_cell.sv
// One cell of the output chain: holds a single packet beat.
// Depends on scpf_pkg for the beat type.
module scpf_cell
  import scpf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  logic       shift_i,
  input  scpf_beat_t load_beat_i,
  input  scpf_beat_t next_beat_i,
  output scpf_beat_t beat_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q, data_d;
  logic       last_q, last_d;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    last_d  = last_q;
    if (load_i) begin
      valid_d = load_beat_i.valid;
      data_d  = load_beat_i.data;
      last_d  = load_beat_i.last;
    end else if (shift_i) begin
      valid_d = next_beat_i.valid;
      data_d  = next_beat_i.data;
      last_d  = next_beat_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    last_q <= last_d;
  end

  assign beat_o = '{valid: valid_q, data: data_q, last: last_q};

endmodule

// File: sv/scpf_builder.sv
// Packet builder: lays out one command as a row of beats and forms the checksum.
// Depends on scpf_pkg for constants and the beat type.
module scpf_builder
  import scpf_pkg::*;
#(
  parameter int unsigned LIMIT = MAX_PARAMS_DEF,
  parameter int unsigned DEPTH = FIXED_BYTES + LIMIT
) (
  input  logic [31:0]                   device_address_i,
  input  logic [7:0]                    opcode_i,
  input  logic [2:0]                    param_count_i,
  input  logic [PARAM_FIELDS-1:0][7:0]  params_i,
  output scpf_beat_t [DEPTH-1:0]        packet_o
);

  logic [2:0]  cnt;
  logic [15:0] length;
  logic [15:0] sum;

  // Saturate the count to the usable parameter fields.
  assign cnt    = (32'(param_count_i) > LIMIT) ? 3'(LIMIT) : param_count_i;
  assign length = 16'(cnt) + 16'd3;

  always_comb begin
    sum = 16'(PKT_FLAG) + length + 16'(opcode_i);
    for (int j = 0; j < LIMIT; j++) begin
      if (j < 32'(cnt)) begin
        sum = sum + 16'(params_i[j]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      packet_o[i].valid = (i < 32'(cnt) + FIXED_BYTES);
      packet_o[i].last  = (i == 32'(cnt) + FIXED_BYTES - 1);
      packet_o[i].data  = 8'h00;
      case (i)
        0:       packet_o[i].data = HDR_HI;
        1:       packet_o[i].data = HDR_LO;
        2:       packet_o[i].data = device_address_i[31:24];
        3:       packet_o[i].data = device_address_i[23:16];
        4:       packet_o[i].data = device_address_i[15:8];
        5:       packet_o[i].data = device_address_i[7:0];
        6:       packet_o[i].data = PKT_FLAG;
        7:       packet_o[i].data = length[15:8];
        8:       packet_o[i].data = length[7:0];
        9:       packet_o[i].data = opcode_i;
        default: begin
          if (i < 32'(cnt) + 10) begin
            packet_o[i].data =
              params_i[(i + PARAM_FIELDS - 10 % PARAM_FIELDS) % PARAM_FIELDS];
          end else if (i == 32'(cnt) + 10) begin
            packet_o[i].data = sum[15:8];
          end else begin
            packet_o[i].data = sum[7:0];
          end
        end
      endcase
    end
  end

endmodule

// File: sv/sensor_command_packet_framer.sv
// Top level of the sensor command packet framer.
// Depends on scpf_pkg, scpf_builder and scpf_cell.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one command per beat: an
//   opcode and up to five parameter bytes, param_count_i saying how many
//   are used. Counts beyond the usable fields saturate.
//   Output channel (out_valid_o / out_ready_i) delivers the command packet
//   one byte per beat: EF 01, address (4 bytes, high first), flag 01,
//   length (2 bytes), opcode, parameters, 16-bit checksum; last_o marks
//   the low checksum byte.
//   Configuration: cfg_we_i writes cfg_wdata_i into the device address.
//   The first packet byte is offered in the cycle after acceptance.
//   Throughput: a packet holds 12 + count bytes (12 to 17); the output
//   chain shifts one byte per cycle while out_ready_i is high. A new
//   command is taken in the cycle the final byte of the previous packet
//   leaves, so packets stream without gaps.
//   Reset: the chain empties and the address returns to FFFFFFFF.
//   Stall: while out_ready_i is low a waiting packet holds in the chain and
//   no new command is taken; an empty chain still takes one.
module sensor_command_packet_framer
  import scpf_pkg::*;
#(
  parameter int unsigned MAX_PARAMS = MAX_PARAMS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  opcode_i,
  input  logic [2:0]  param_count_i,
  input  logic [7:0]  param0_i,
  input  logic [7:0]  param1_i,
  input  logic [7:0]  param2_i,
  input  logic [7:0]  param3_i,
  input  logic [7:0]  param4_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  tx_byte_o,
  output logic        last_o
);

  localparam int unsigned LIMIT = (MAX_PARAMS < PARAM_FIELDS) ? MAX_PARAMS : PARAM_FIELDS;
  localparam int unsigned DEPTH = FIXED_BYTES + LIMIT;

  logic [31:0]                  device_address_q;
  logic [PARAM_FIELDS-1:0][7:0] params;
  scpf_beat_t [DEPTH-1:0]       packet;
  scpf_beat_t [DEPTH:0]         chain;   // chain[DEPTH] feeds the tail with an empty beat
  logic                         load;
  logic                         shift;

  // Hold the device address; write it only while the framer is idle (the block does not enforce this).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_address_q <= ADDR_RESET;
    end else if (cfg_we_i) begin
      device_address_q <= cfg_wdata_i;
    end
  end

  assign params = {param4_i, param3_i, param2_i, param1_i, param0_i};

  scpf_builder #(
    .LIMIT (LIMIT),
    .DEPTH (DEPTH)
  ) u_builder (
    .device_address_i (device_address_q),
    .opcode_i         (opcode_i),
    .param_count_i    (param_count_i),
    .params_i         (params),
    .packet_o         (packet)
  );

  // Packets always sit aligned at the head, so the head cell is valid
  // whenever any cell is. Take a new command when the chain is empty or
  // when only the head beat remains and it is being taken.
  assign shift      = chain[0].valid && out_ready_i;
  assign in_ready_o = !chain[0].valid || (!chain[1].valid && out_ready_i);
  assign load       = in_valid_i && in_ready_o;

  assign chain[DEPTH] = '{valid: 1'b0, data: 8'h00, last: 1'b0};

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    scpf_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .load_i      (load),
      .shift_i     (shift),
      .load_beat_i (packet[k]),
      .next_beat_i (chain[k+1]),
      .beat_o      (chain[k])
    );
  end

  // Drive the output beat straight from the head cell.
  assign out_valid_o = chain[0].valid;
  assign tx_byte_o   = chain[0].data;
  assign last_o      = chain[0].last;

endmodule
